[rtl/rmot_pkg.sv]
// shared types, constants and command codes for the relay minimum off time guard
package rmot_pkg;

  // number of relays and derived index width
  localparam int NUM_RELAYS = 2;
  localparam int RELAY_IDX_W = (NUM_RELAYS > 1) ? $clog2(NUM_RELAYS) : 1;
  // relays reported in the status bits
  localparam int STATUS_BITS = (NUM_RELAYS < 2) ? NUM_RELAYS : 2;

  // hold-off timer
  localparam int HOLD_W = 16;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd2000;

  // register file
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_HOLD_OFF = 1'b0;

  // command codes
  localparam logic [2:0] CMD_ON     = 3'd0;
  localparam logic [2:0] CMD_OFF    = 3'd1;
  localparam logic [2:0] CMD_TOGGLE = 3'd2;
  localparam logic [2:0] CMD_UPDATE = 3'd3;
  localparam logic [2:0] CMD_TICK   = 3'd4;
  localparam logic [2:0] CMD_STATUS = 3'd5;

  typedef struct packed {
    logic [2:0] cmd;
    logic       relay_sel;
  } in_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] relays_on;
    logic [1:0] relays_pending;
  } out_t;

  // register write from the bus side to the controller
  typedef struct packed {
    logic              we;
    logic [HOLD_W-1:0] data;
  } cfg_wr_t;

endpackage

[rtl/relay_min_off_time_guard_top.sv]
// top level: register port, command channel and result register
//
//  channel   direction  signals                               payload
//  in        input      in_valid / in_ready                   in_data (cmd, relay_sel)
//  out       output     out_valid / out_ready                 out_data (accepted, relays_on,
//                                                               relays_pending)
//  config    apb        psel penable pwrite paddr pwdata ...  hold_off_ticks at 0x0
//
// every transaction is decoded combinationally; the result is registered at the edge that
// takes the command; so does the state, unless a register write comes in that cycle;
// one command enters per cycle, as the result register accepts a new command while its
// previous result is taken; out_ready low with a full result register holds in_ready low
// synchronous reset clears all relay state, loads the hold-off of 2000 ticks
module relay_min_off_time_guard_top
  import rmot_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic              accept;
  cfg_wr_t           cfg_wr;
  logic [HOLD_W-1:0] hold_off;
  out_t              result;

  // register access
  assign pready      = 1'b1;
  assign cfg_wr.we   = psel && penable && pwrite && (paddr[2] == REG_HOLD_OFF);
  assign cfg_wr.data = pwdata[HOLD_W-1:0];

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_HOLD_OFF) begin
      prdata[HOLD_W-1:0] = hold_off;
    end
  end

  // command handshake
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  rmot_relay_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .step_en  (accept),
    .item     (in_data),
    .cfg_wr   (cfg_wr),
    .hold_off (hold_off),
    .result   (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  // every taken command yields a result next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("command taken without result");

  // a result not taken is not overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !accept)
    else $error("result overwritten");

  // a result only appears after a command was taken
  a_result_from_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(accept))
    else $error("result without command");

endmodule

[rtl/rmot_relay_ctrl.sv]
// per-relay state, hold-off timers and the command decode for one transaction
module rmot_relay_ctrl
  import rmot_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step_en,
  input  in_t               item,
  input  cfg_wr_t           cfg_wr,
  output logic [HOLD_W-1:0] hold_off,
  output out_t              result
);

  logic [HOLD_W-1:0]     hold_count [NUM_RELAYS];
  logic [HOLD_W-1:0]     hold_count_next [NUM_RELAYS];
  logic [NUM_RELAYS-1:0] hold_running;
  logic [NUM_RELAYS-1:0] hold_running_next;
  logic [NUM_RELAYS-1:0] pending_on;
  logic [NUM_RELAYS-1:0] pending_on_next;
  logic [NUM_RELAYS-1:0] commanded_on;
  logic [NUM_RELAYS-1:0] commanded_on_next;
  logic [NUM_RELAYS-1:0] output_on;
  logic [NUM_RELAYS-1:0] output_on_next;
  logic [RELAY_IDX_W-1:0] r;
  logic                  do_on;
  logic                  do_off;
  logic                  acc;

  // relay select, clamped to the last relay
  always_comb begin
    if (int'(item.relay_sel) >= NUM_RELAYS) begin
      r = RELAY_IDX_W'(NUM_RELAYS - 1);
    end else begin
      r = RELAY_IDX_W'(item.relay_sel);
    end
  end

  // next state for the command
  always_comb begin
    hold_count_next   = hold_count;
    hold_running_next = hold_running;
    pending_on_next   = pending_on;
    commanded_on_next = commanded_on;
    output_on_next    = output_on;
    do_on             = 1'b0;
    do_off            = 1'b0;
    acc               = 1'b1;

    unique case (item.cmd)
      CMD_ON:  do_on = 1'b1;
      CMD_OFF: do_off = 1'b1;
      CMD_TOGGLE: begin
        if (output_on[r] || pending_on[r]) begin
          do_off = 1'b1;
        end else begin
          do_on = 1'b1;
        end
      end
      CMD_UPDATE: begin
        // retry pending requests, then drive the outputs
        for (int i = 0; i < NUM_RELAYS; i++) begin
          if (pending_on[i] && !hold_running[i]) begin
            pending_on_next[i]   = 1'b0;
            commanded_on_next[i] = 1'b1;
          end
        end
        output_on_next = commanded_on_next;
      end
      CMD_TICK: begin
        // count running timers down, stop and reload at the end
        for (int i = 0; i < NUM_RELAYS; i++) begin
          if (hold_running[i]) begin
            if (hold_count[i] <= HOLD_W'(1)) begin
              hold_running_next[i] = 1'b0;
              hold_count_next[i]   = hold_off;
            end else begin
              hold_count_next[i] = hold_count[i] - HOLD_W'(1);
            end
          end
        end
      end
      CMD_STATUS: ;
      default: acc = 1'b0;
    endcase

    // turn-on, deferred while the hold-off runs
    if (do_on) begin
      if (hold_running[r]) begin
        pending_on_next[r] = 1'b1;
        acc = 1'b0;
      end else begin
        pending_on_next[r]   = 1'b0;
        commanded_on_next[r] = 1'b1;
      end
    end

    // turn-off starts the hold-off unless a request was waiting
    if (do_off) begin
      if (!pending_on[r]) begin
        hold_running_next[r] = 1'b1;
      end
      output_on_next[r]    = 1'b0;
      pending_on_next[r]   = 1'b0;
      commanded_on_next[r] = 1'b0;
    end
  end

  // result fields
  always_comb begin
    result = '0;
    result.accepted = acc;
    for (int i = 0; i < STATUS_BITS; i++) begin
      result.relays_on[i]      = output_on_next[i];
      result.relays_pending[i] = pending_on_next[i];
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_off     <= HOLD_RESET;
      hold_running <= '0;
      pending_on   <= '0;
      commanded_on <= '0;
      output_on    <= '0;
      for (int i = 0; i < NUM_RELAYS; i++) begin
        hold_count[i] <= HOLD_RESET;
      end
    end else if (cfg_wr.we) begin
      hold_off <= cfg_wr.data;
      for (int i = 0; i < NUM_RELAYS; i++) begin
        if (!hold_running[i]) begin
          hold_count[i] <= cfg_wr.data;
        end
      end
    end else if (step_en) begin
      hold_count   <= hold_count_next;
      hold_running <= hold_running_next;
      pending_on   <= pending_on_next;
      commanded_on <= commanded_on_next;
      output_on    <= output_on_next;
    end
  end

  // a driven relay is always a commanded one
  a_output_implies_cmd: assert property (@(posedge clk) disable iff (rst)
    (output_on & ~commanded_on) == '0)
    else $error("relay driven without command");

  // a commanded relay has no waiting request
  a_pending_excl_cmd: assert property (@(posedge clk) disable iff (rst)
    (pending_on & commanded_on) == '0)
    else $error("relay both pending and commanded");

  // no command is set while the hold-off runs
  a_cmd_excl_running: assert property (@(posedge clk) disable iff (rst)
    (commanded_on & hold_running) == '0)
    else $error("relay commanded during hold-off");

  // an idle timer of relay 0 always holds the reload value
  a_idle_count_reloaded: assert property (@(posedge clk) disable iff (rst)
    !hold_running[0] |-> hold_count[0] == hold_off)
    else $error("idle timer not reloaded");

endmodule
